[rtl/rtse_pkg.sv]
package rtse_pkg;

	localparam int NUM_CONN  = 8;
	localparam int SLOT_W    = 3;
	localparam int BUF_BYTES = 4096;
	localparam int PTR_W     = 12;
	localparam int CNT_W     = 13;
	localparam int STORE_DEPTH = NUM_CONN * BUF_BYTES;

	typedef enum logic [2:0] {
		ACT_OPEN    = 3'd0,
		ACT_LISTEN  = 3'd1,
		ACT_HEADER  = 3'd2,
		ACT_PAYLOAD = 3'd3,
		ACT_TICK    = 3'd4,
		ACT_READ    = 3'd5,
		ACT_CLOSE   = 3'd6,
		ACT_NONE    = 3'd7
	} act_t;

	localparam logic [2:0] SEG_SYN     = 3'd0;
	localparam logic [2:0] SEG_SYNACK  = 3'd1;
	localparam logic [2:0] SEG_FIN     = 3'd2;
	localparam logic [2:0] SEG_FINACK  = 3'd3;
	localparam logic [2:0] SEG_DATA    = 3'd4;
	localparam logic [2:0] SEG_DATAACK = 3'd5;

	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_LISTEN = 2'd1;
	localparam logic [1:0] ST_CONN   = 2'd2;
	localparam logic [1:0] ST_CWAIT  = 2'd3;

	localparam logic [1:0] RC_OK      = 2'd0;
	localparam logic [1:0] RC_REFUSED = 2'd1;
	localparam logic [1:0] RC_EMPTY   = 2'd2;
	localparam logic [1:0] RC_NOMATCH = 2'd3;

	localparam logic [15:0] CW_TICKS_RST = 16'd10;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic exec;
		logic resp;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_act;
		logic scan_last;
		logic out_busy;
	} dp_sts_t;

endpackage

[rtl/rtse_ctrl.sv]
module rtse_ctrl
	import rtse_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {IDLE, SCAN, EXEC, RESP} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= SCAN;
				SCAN: if (!sts.scan_act || sts.scan_last) state_q <= EXEC;
				EXEC: state_q <= RESP;
				RESP: if (!sts.out_busy) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == IDLE);
	assign cmd.load      = (state_q == IDLE) && in_valid;
	assign cmd.scan_clr  = (state_q == IDLE);
	assign cmd.scan_step = (state_q == SCAN) && sts.scan_act;
	assign cmd.exec      = (state_q == EXEC);
	assign cmd.resp      = (state_q == RESP) && !sts.out_busy;

endmodule

[rtl/rtse_dp.sv]
module rtse_dp
	import rtse_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	output dp_sts_t       sts,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	input  logic [2:0]    action,
	input  logic [2:0]    sock_index,
	input  logic [15:0]   local_port,
	input  logic [7:0]    seg_node,
	input  logic [15:0]   seg_sport,
	input  logic [15:0]   seg_dport,
	input  logic [2:0]    seg_type,
	input  logic [31:0]   seq_num,
	input  logic [12:0]   payload_len,
	input  logic [7:0]    payload_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    result_code,
	output logic [2:0]    slot_out,
	output logic [1:0]    conn_state_out,
	output logic          send_reply,
	output logic [2:0]    reply_type,
	output logic [7:0]    reply_node,
	output logic [15:0]   reply_src_port,
	output logic [15:0]   reply_dest_port,
	output logic [31:0]   reply_ack,
	output logic [7:0]    read_data
);

	act_t        act_q;
	logic [2:0]  sk_q, type_q;
	logic [15:0] port_q, sport_q, dport_q;
	logic [7:0]  node_q, byte_q;
	logic [31:0] seq_q;
	logic [12:0] len_q;

	logic [15:0]      cw_ticks_q;
	logic             used_q  [NUM_CONN];
	logic [1:0]       st_q    [NUM_CONN];
	logic [15:0]      srv_q   [NUM_CONN];
	logic [15:0]      cli_q   [NUM_CONN];
	logic [7:0]       cnode_q [NUM_CONN];
	logic [31:0]      exp_q   [NUM_CONN];
	logic [CNT_W-1:0] cnt_q   [NUM_CONN];
	logic [PTR_W-1:0] head_q  [NUM_CONN];
	logic [15:0]      tmr_q   [NUM_CONN];
	logic [12:0]       prem_q;
	logic [SLOT_W-1:0] pslot_q;
	logic              keep_q;

	logic [SLOT_W-1:0] idx_q, hit_idx_q, free_idx_q;
	logic              hit_q, free_q, bound_q;

	logic [1:0]  r_code_q, r_cst_q;
	logic [2:0]  r_slot_q, r_type_q;
	logic        r_send_q, r_rd_q;
	logic [7:0]  r_node_q;
	logic [15:0] r_sport_q, r_dport_q;
	logic [31:0] r_ack_q;

	logic [7:0] store [STORE_DEPTH];
	logic [7:0] mem_q;

	logic             out_valid_q;
	logic [1:0]       o_code_q, o_cst_q;
	logic [2:0]       o_slot_q, o_type_q;
	logic             o_send_q;
	logic [7:0]       o_node_q, o_rd_q;
	logic [15:0]      o_sport_q, o_dport_q;
	logic [31:0]      o_ack_q;

	logic             over;
	logic             hdr_reply;
	logic [PTR_W-1:0] wpos;
	logic             wr_en, rd_en;
	logic [31:0]      exp_new;

	assign over    = ({1'b0, len_q} + {1'b0, cnt_q[hit_idx_q]}) > 14'(BUF_BYTES);
	assign exp_new = exp_q[hit_idx_q] + 32'(len_q);
	assign wpos    = head_q[pslot_q] + cnt_q[pslot_q][PTR_W-1:0];
	assign wr_en   = cmd.exec && act_q == ACT_PAYLOAD && prem_q != '0 && keep_q
		&& cnt_q[pslot_q] < CNT_W'(BUF_BYTES);
	assign rd_en   = cmd.exec && act_q == ACT_READ && used_q[sk_q] && cnt_q[sk_q] != '0;

	// header segments that get a reply
	assign hdr_reply = (st_q[hit_idx_q] == ST_LISTEN && type_q == SEG_SYN)
		|| (st_q[hit_idx_q] == ST_CONN && (type_q == SEG_SYN || type_q == SEG_FIN
			|| (type_q == SEG_DATA && !over)))
		|| (st_q[hit_idx_q] == ST_CWAIT && type_q == SEG_FIN);

	assign sts.scan_act  = act_q == ACT_OPEN || act_q == ACT_HEADER || act_q == ACT_TICK;
	assign sts.scan_last = idx_q == SLOT_W'(NUM_CONN - 1);
	assign sts.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[{pslot_q, wpos}] <= byte_q;
		end
		if (rd_en) begin
			mem_q <= store[{sk_q, head_q[sk_q]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= act_t'(action);
			sk_q    <= sock_index;
			port_q  <= local_port;
			node_q  <= seg_node;
			sport_q <= seg_sport;
			dport_q <= seg_dport;
			type_q  <= seg_type;
			seq_q   <= seq_num;
			len_q   <= payload_len;
			byte_q  <= payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_ticks_q <= CW_TICKS_RST;
			prem_q     <= '0;
			pslot_q    <= '0;
			keep_q     <= 1'b0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			bound_q    <= 1'b0;
			r_code_q   <= RC_OK;
			r_cst_q    <= ST_CLOSED;
			r_slot_q   <= '0;
			r_type_q   <= '0;
			r_send_q   <= 1'b0;
			r_rd_q     <= 1'b0;
			r_node_q   <= '0;
			r_sport_q  <= '0;
			r_dport_q  <= '0;
			r_ack_q    <= '0;
			for (int i = 0; i < NUM_CONN; i++) begin
				used_q[i]  <= 1'b0;
				st_q[i]    <= ST_CLOSED;
				srv_q[i]   <= '0;
				cli_q[i]   <= '0;
				cnode_q[i] <= '0;
				exp_q[i]   <= '0;
				cnt_q[i]   <= '0;
				head_q[i]  <= '0;
				tmr_q[i]   <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				cw_ticks_q <= cfg_wr_data;
			end
			if (cmd.scan_clr) begin
				idx_q   <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
				bound_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				unique case (act_q)
					ACT_OPEN: begin
						if (used_q[idx_q] && srv_q[idx_q] == port_q) bound_q <= 1'b1;
						if (!used_q[idx_q] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_q;
						end
					end
					ACT_HEADER: begin
						if (!hit_q && used_q[idx_q] && srv_q[idx_q] == dport_q
							&& (type_q == SEG_SYN || cli_q[idx_q] == sport_q)) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_q;
						end
					end
					default: begin
						if (used_q[idx_q] && st_q[idx_q] == ST_CWAIT) begin
							if (tmr_q[idx_q] <= 16'd1) begin
								tmr_q[idx_q]  <= '0;
								st_q[idx_q]   <= ST_CLOSED;
								cnt_q[idx_q]  <= '0;
								head_q[idx_q] <= '0;
								if (pslot_q == idx_q) keep_q <= 1'b0;
							end else begin
								tmr_q[idx_q] <= tmr_q[idx_q] - 16'd1;
							end
						end
					end
				endcase
			end
			if (cmd.exec) begin
				r_code_q  <= RC_OK;
				r_cst_q   <= ST_CLOSED;
				r_slot_q  <= '0;
				r_type_q  <= '0;
				r_send_q  <= 1'b0;
				r_rd_q    <= 1'b0;
				r_node_q  <= '0;
				r_sport_q <= '0;
				r_dport_q <= '0;
				r_ack_q   <= '0;
				unique case (act_q)
					ACT_OPEN: begin
						r_code_q <= RC_REFUSED;
						if (!bound_q && free_q) begin
							used_q[free_idx_q]  <= 1'b1;
							st_q[free_idx_q]    <= ST_CLOSED;
							srv_q[free_idx_q]   <= port_q;
							cli_q[free_idx_q]   <= '0;
							cnode_q[free_idx_q] <= '0;
							exp_q[free_idx_q]   <= '0;
							cnt_q[free_idx_q]   <= '0;
							head_q[free_idx_q]  <= '0;
							tmr_q[free_idx_q]   <= '0;
							if (pslot_q == free_idx_q) keep_q <= 1'b0;
							r_code_q <= RC_OK;
							r_slot_q <= free_idx_q;
						end
					end
					ACT_LISTEN, ACT_READ, ACT_CLOSE: begin
						r_slot_q <= sk_q;
						if (!used_q[sk_q]) begin
							r_code_q <= RC_NOMATCH;
						end else if (act_q == ACT_LISTEN) begin
							st_q[sk_q] <= ST_LISTEN;
							r_cst_q    <= ST_LISTEN;
						end else if (act_q == ACT_READ) begin
							r_cst_q <= st_q[sk_q];
							if (cnt_q[sk_q] == '0) begin
								r_code_q <= RC_EMPTY;
							end else begin
								r_rd_q       <= 1'b1;
								head_q[sk_q] <= head_q[sk_q] + 1'b1;
								cnt_q[sk_q]  <= cnt_q[sk_q] - 1'b1;
							end
						end else if (st_q[sk_q] != ST_CLOSED) begin
							r_code_q <= RC_REFUSED;
							r_cst_q  <= st_q[sk_q];
						end else begin
							used_q[sk_q]  <= 1'b0;
							srv_q[sk_q]   <= '0;
							cli_q[sk_q]   <= '0;
							cnode_q[sk_q] <= '0;
							exp_q[sk_q]   <= '0;
							cnt_q[sk_q]   <= '0;
							head_q[sk_q]  <= '0;
							tmr_q[sk_q]   <= '0;
							if (pslot_q == sk_q) keep_q <= 1'b0;
						end
					end
					ACT_HEADER: begin
						prem_q   <= len_q;
						keep_q   <= 1'b0;
						pslot_q  <= '0;
						r_code_q <= RC_NOMATCH;
						if (hit_q) begin
							pslot_q   <= hit_idx_q;
							r_slot_q  <= hit_idx_q;
							r_cst_q   <= st_q[hit_idx_q];
							if (hdr_reply) begin
								r_node_q  <= node_q;
								r_sport_q <= srv_q[hit_idx_q];
								r_dport_q <= cli_q[hit_idx_q];
							end
							unique case (st_q[hit_idx_q])
								ST_LISTEN: begin
									if (type_q == SEG_SYN) begin
										cli_q[hit_idx_q]   <= sport_q;
										exp_q[hit_idx_q]   <= seq_q;
										cnode_q[hit_idx_q] <= node_q;
										st_q[hit_idx_q]    <= ST_CONN;
										r_cst_q   <= ST_CONN;
										r_dport_q <= sport_q;
										r_send_q  <= 1'b1;
										r_type_q  <= SEG_SYNACK;
										r_code_q  <= RC_OK;
									end
								end
								ST_CONN: begin
									if (type_q == SEG_SYN) begin
										r_send_q <= 1'b1;
										r_type_q <= SEG_SYNACK;
										r_code_q <= RC_OK;
									end else if (type_q == SEG_FIN) begin
										st_q[hit_idx_q]  <= ST_CWAIT;
										tmr_q[hit_idx_q] <= cw_ticks_q;
										r_cst_q  <= ST_CWAIT;
										r_send_q <= 1'b1;
										r_type_q <= SEG_FINACK;
										r_code_q <= RC_OK;
									end else if (type_q == SEG_DATA && !over) begin
										r_send_q <= 1'b1;
										r_type_q <= SEG_DATAACK;
										r_code_q <= RC_OK;
										if (seq_q == exp_q[hit_idx_q]) begin
											exp_q[hit_idx_q] <= exp_new;
											keep_q  <= 1'b1;
											r_ack_q <= exp_new;
										end else begin
											r_ack_q <= exp_q[hit_idx_q];
										end
									end
								end
								ST_CWAIT: begin
									if (type_q == SEG_FIN) begin
										r_send_q <= 1'b1;
										r_type_q <= SEG_FINACK;
										r_code_q <= RC_OK;
									end
								end
								default: ;
							endcase
						end
					end
					ACT_PAYLOAD: begin
						if (prem_q == '0) begin
							r_code_q <= RC_NOMATCH;
						end else begin
							prem_q   <= prem_q - 1'b1;
							r_slot_q <= pslot_q;
							r_cst_q  <= st_q[pslot_q];
							if (wr_en) cnt_q[pslot_q] <= cnt_q[pslot_q] + 1'b1;
						end
					end
					ACT_TICK: ;
					default: r_code_q <= RC_NOMATCH;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			o_code_q  <= r_code_q;
			o_slot_q  <= r_slot_q;
			o_cst_q   <= r_cst_q;
			o_send_q  <= r_send_q;
			o_type_q  <= r_type_q;
			o_node_q  <= r_node_q;
			o_sport_q <= r_sport_q;
			o_dport_q <= r_dport_q;
			o_ack_q   <= r_ack_q;
			o_rd_q    <= r_rd_q ? mem_q : 8'd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_code     = o_code_q;
	assign slot_out        = o_slot_q;
	assign conn_state_out  = o_cst_q;
	assign send_reply      = o_send_q;
	assign reply_type      = o_type_q;
	assign reply_node      = o_node_q;
	assign reply_src_port  = o_sport_q;
	assign reply_dest_port = o_dport_q;
	assign reply_ack       = o_ack_q;
	assign read_data       = o_rd_q;

endmodule

[rtl/reliable_transport_server_engine_top.sv]
// Server side of a small reliable transport with an 8-slot connection table.
// Input channel (in_valid/in_ready) carries one request: open, listen,
// segment header, payload byte, tick, read byte or close.
// Output channel (out_valid/out_ready) returns exactly one result per request.
// Configuration: cfg_wr_en/cfg_wr_data write closewait_ticks, no wait.
// Open, header and tick scan the table one slot per cycle; other requests
// do not scan it. One request is in flight at a time; the next is accepted
// once the previous result is in the output register.
// Reset clears the table, the payload tracker and the output valid flag;
// closewait_ticks returns to 10. The receive buffer memory is not cleared.
// When the receiver stalls, the result holds in the output register and the
// engine waits with the next result until it is taken.
module reliable_transport_server_engine_top
	import rtse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [2:0]  sock_index,
	input  logic [15:0] local_port,
	input  logic [7:0]  seg_node,
	input  logic [15:0] seg_sport,
	input  logic [15:0] seg_dport,
	input  logic [2:0]  seg_type,
	input  logic [31:0] seq_num,
	input  logic [12:0] payload_len,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_code,
	output logic [2:0]  slot_out,
	output logic [1:0]  conn_state_out,
	output logic        send_reply,
	output logic [2:0]  reply_type,
	output logic [7:0]  reply_node,
	output logic [15:0] reply_src_port,
	output logic [15:0] reply_dest_port,
	output logic [31:0] reply_ack,
	output logic [7:0]  read_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rtse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtse_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.action          (action),
		.sock_index      (sock_index),
		.local_port      (local_port),
		.seg_node        (seg_node),
		.seg_sport       (seg_sport),
		.seg_dport       (seg_dport),
		.seg_type        (seg_type),
		.seq_num         (seq_num),
		.payload_len     (payload_len),
		.payload_byte    (payload_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_code     (result_code),
		.slot_out        (slot_out),
		.conn_state_out  (conn_state_out),
		.send_reply      (send_reply),
		.reply_type      (reply_type),
		.reply_node      (reply_node),
		.reply_src_port  (reply_src_port),
		.reply_dest_port (reply_dest_port),
		.reply_ack       (reply_ack),
		.read_data       (read_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while engine busy");

	a_result_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");

	a_empty_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_code == RC_EMPTY |-> !send_reply)
		else $error("reply on empty read");

	a_ack_only_dataack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_type != SEG_DATAACK |-> reply_ack == 32'd0)
		else $error("ack on non-DATAACK result");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import rtse_pkg::*;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  sock;
		logic [15:0] lport;
		logic [7:0]  node;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [2:0]  seg;
		logic [31:0] seq;
		logic [12:0] len;
		logic [7:0]  pbyte;
	} conn_req_t;

	typedef struct packed {
		logic [1:0]  rc;
		logic [2:0]  slot;
		logic [1:0]  st;
		logic        rep;
		logic [2:0]  rtype;
		logic [7:0]  rnode;
		logic [15:0] rsport;
		logic [15:0] rdport;
		logic [31:0] rack;
		logic [7:0]  rdata;
	} conn_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [2:0]  sock_index;
	logic [15:0] local_port;
	logic [7:0]  seg_node;
	logic [15:0] seg_sport;
	logic [15:0] seg_dport;
	logic [2:0]  seg_type;
	logic [31:0] seq_num;
	logic [12:0] payload_len;
	logic [7:0]  payload_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_code;
	logic [2:0]  slot_out;
	logic [1:0]  conn_state_out;
	logic        send_reply;
	logic [2:0]  reply_type;
	logic [7:0]  reply_node;
	logic [15:0] reply_src_port;
	logic [15:0] reply_dest_port;
	logic [31:0] reply_ack;
	logic [7:0]  read_data;

	reliable_transport_server_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .sock_index(sock_index), .local_port(local_port),
		.seg_node(seg_node), .seg_sport(seg_sport), .seg_dport(seg_dport),
		.seg_type(seg_type), .seq_num(seq_num), .payload_len(payload_len),
		.payload_byte(payload_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_code(result_code), .slot_out(slot_out),
		.conn_state_out(conn_state_out), .send_reply(send_reply),
		.reply_type(reply_type), .reply_node(reply_node),
		.reply_src_port(reply_src_port), .reply_dest_port(reply_dest_port),
		.reply_ack(reply_ack), .read_data(read_data)
	);

	// shadow connection table
	logic [15:0] cw_ticks;
	logic        used_m [NUM_CONN];
	logic [1:0]  state_m [NUM_CONN];
	logic [15:0] srv_port_m [NUM_CONN];
	logic [15:0] cli_port_m [NUM_CONN];
	logic [7:0]  cli_node_m [NUM_CONN];
	logic [31:0] exp_seq_m [NUM_CONN];
	logic [12:0] count_m [NUM_CONN];
	logic [11:0] head_m [NUM_CONN];
	logic [15:0] timer_m [NUM_CONN];
	logic [7:0]  rx_bytes [STORE_DEPTH];
	logic [12:0] pend_left;
	logic [2:0]  pend_slot;
	logic        pend_keep;

	conn_result_t expected_q[$];
	int errors;
	int sent;
	logic hold_rx;

	function automatic void free_slot(int s);
		used_m[s] = 0;
		state_m[s] = ST_CLOSED;
		srv_port_m[s] = 0;
		cli_port_m[s] = 0;
		cli_node_m[s] = 0;
		exp_seq_m[s] = 0;
		count_m[s] = 0;
		head_m[s] = 0;
		timer_m[s] = 0;
		if (pend_slot == s)
			pend_keep = 0;
	endfunction

	function automatic void table_reset();
		cw_ticks = CW_TICKS_RST;
		pend_left = 0;
		pend_slot = 0;
		pend_keep = 0;
		for (int i = 0; i < NUM_CONN; i++)
			free_slot(i);
	endfunction

	function automatic void fill_reply(inout conn_result_t r, input int s,
			input logic [2:0] t, input logic [7:0] node);
		r.rep = 1;
		r.rtype = t;
		r.rnode = node;
		r.rsport = srv_port_m[s];
		r.rdport = cli_port_m[s];
		r.rack = (t == SEG_DATAACK) ? exp_seq_m[s] : 32'd0;
	endfunction

	function automatic conn_result_t predict_result(conn_req_t q);
		conn_result_t r;
		int s;
		int pos;
		r = '0;
		case (q.action)
		ACT_OPEN: begin
			r.rc = RC_REFUSED;
			for (int i = 0; i < NUM_CONN; i++)
				if (used_m[i] && srv_port_m[i] == q.lport)
					return r;
			for (int i = 0; i < NUM_CONN; i++)
				if (!used_m[i]) begin
					free_slot(i);
					used_m[i] = 1;
					srv_port_m[i] = q.lport;
					r.rc = RC_OK;
					r.slot = i[2:0];
					return r;
				end
		end
		ACT_LISTEN, ACT_READ, ACT_CLOSE: begin
			s = q.sock;
			r.slot = q.sock;
			if (!used_m[s]) begin
				r.rc = RC_NOMATCH;
				return r;
			end
			if (q.action == ACT_LISTEN) begin
				state_m[s] = ST_LISTEN;
			end else if (q.action == ACT_READ) begin
				if (count_m[s] == 0) begin
					r.rc = RC_EMPTY;
				end else begin
					r.rdata = rx_bytes[{q.sock, head_m[s]}];
					head_m[s] = head_m[s] + 12'd1;
					count_m[s] = count_m[s] - 13'd1;
				end
			end else if (state_m[s] != ST_CLOSED) begin
				r.rc = RC_REFUSED;
			end else begin
				free_slot(s);
			end
			r.st = state_m[s];
		end
		ACT_HEADER: begin
			s = -1;
			for (int i = 0; i < NUM_CONN; i++)
				if (s < 0 && used_m[i] && srv_port_m[i] == q.dport &&
						(q.seg == SEG_SYN || cli_port_m[i] == q.sport))
					s = i;
			pend_left = q.len;
			pend_keep = 0;
			pend_slot = 0;
			r.rc = RC_NOMATCH;
			if (s < 0)
				return r;
			pend_slot = s[2:0];
			r.slot = s[2:0];
			case (state_m[s])
			ST_LISTEN: begin
				if (q.seg == SEG_SYN) begin
					cli_port_m[s] = q.sport;
					exp_seq_m[s] = q.seq;
					cli_node_m[s] = q.node;
					state_m[s] = ST_CONN;
					fill_reply(r, s, SEG_SYNACK, q.node);
					r.rc = RC_OK;
				end
			end
			ST_CONN: begin
				if (q.seg == SEG_SYN) begin
					fill_reply(r, s, SEG_SYNACK, q.node);
					r.rc = RC_OK;
				end else if (q.seg == SEG_FIN) begin
					state_m[s] = ST_CWAIT;
					timer_m[s] = cw_ticks;
					fill_reply(r, s, SEG_FINACK, q.node);
					r.rc = RC_OK;
				end else if (q.seg == SEG_DATA &&
						int'(q.len) + int'(count_m[s]) <= BUF_BYTES) begin
					if (q.seq == exp_seq_m[s]) begin
						exp_seq_m[s] = exp_seq_m[s] + 32'(q.len);
						pend_keep = 1;
					end
					fill_reply(r, s, SEG_DATAACK, q.node);
					r.rc = RC_OK;
				end
			end
			ST_CWAIT: begin
				if (q.seg == SEG_FIN) begin
					fill_reply(r, s, SEG_FINACK, q.node);
					r.rc = RC_OK;
				end
			end
			default: ;
			endcase
			r.st = state_m[s];
		end
		ACT_PAYLOAD: begin
			s = pend_slot;
			if (pend_left == 0) begin
				r.rc = RC_NOMATCH;
				return r;
			end
			pend_left = pend_left - 13'd1;
			r.slot = pend_slot;
			r.st = state_m[s];
			if (pend_keep && int'(count_m[s]) < BUF_BYTES) begin
				pos = (int'(head_m[s]) + int'(count_m[s])) % BUF_BYTES;
				rx_bytes[s * BUF_BYTES + pos] = q.pbyte;
				count_m[s] = count_m[s] + 13'd1;
			end
		end
		ACT_TICK: begin
			for (int i = 0; i < NUM_CONN; i++)
				if (used_m[i] && state_m[i] == ST_CWAIT) begin
					if (timer_m[i] <= 16'd1) begin
						timer_m[i] = 0;
						state_m[i] = ST_CLOSED;
						count_m[i] = 0;
						head_m[i] = 0;
						if (pend_slot == i)
							pend_keep = 0;
					end else begin
						timer_m[i] = timer_m[i] - 16'd1;
					end
				end
		end
		default: r.rc = RC_NOMATCH;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("testbench: errors");
		$finish;
	end

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (hold_rx)
			out_ready <= 0;
		else if ($urandom_range(0, 99) < 3)
			out_ready <= 0;
		else if (!out_ready && $urandom_range(0, 99) < 12)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(0, 99) < 80) || !out_ready;
	end

	always @(posedge clk) begin
		conn_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {result_code, slot_out, conn_state_out, send_reply, reply_type,
				reply_node, reply_src_port, reply_dest_port, reply_ack, read_data};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch rc %0d/%0d slot %0d/%0d st %0d/%0d rep %0d/%0d",
							want.rc, got.rc, want.slot, got.slot, want.st, got.st,
							want.rep, got.rep);
						$display("  type %0d/%0d node %h/%h sp %h/%h dp %h/%h",
							want.rtype, got.rtype, want.rnode, got.rnode,
							want.rsport, got.rsport, want.rdport, got.rdport);
						$display("  ack %h/%h data %h/%h",
							want.rack, got.rack, want.rdata, got.rdata);
					end
				end
			end
		end
	end

	task automatic send_req(input conn_req_t q, output conn_result_t r);
		int gap;
		@(negedge clk);
		{action, sock_index, local_port, seg_node, seg_sport, seg_dport, seg_type,
			seq_num, payload_len, payload_byte} = q;
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		r = predict_result(q);
		expected_q.push_back(r);
		sent++;
		gap = rand_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic do_simple(input logic [2:0] act, input logic [2:0] sk,
			input logic [15:0] lp, output conn_result_t r);
		conn_req_t q;
		q = '0;
		q.action = act;
		q.sock = sk;
		q.lport = lp;
		q.seq = $urandom();
		q.node = 8'($urandom());
		send_req(q, r);
	endtask

	task automatic do_header(input logic [7:0] node, input logic [15:0] sp,
			input logic [15:0] dp, input logic [2:0] t, input logic [31:0] sq,
			input logic [12:0] len, input int nbytes);
		conn_req_t q;
		conn_result_t r;
		q = '0;
		q.action = ACT_HEADER;
		q.node = node;
		q.sport = sp;
		q.dport = dp;
		q.seg = t;
		q.seq = sq;
		q.len = len;
		q.sock = 3'($urandom());
		send_req(q, r);
		for (int i = 0; i < nbytes; i++) begin
			q = '0;
			q.action = ACT_PAYLOAD;
			q.pbyte = 8'($urandom());
			send_req(q, r);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		wait (expected_q.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_ticks(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 0;
		cw_ticks = v;
	endtask

	task automatic test_directed();
		conn_result_t r;
		do_simple(ACT_OPEN, 0, 16'h0000, r);
		do_simple(ACT_OPEN, 0, 16'hFFFF, r);
		do_simple(ACT_OPEN, 0, 16'h0000, r);
		do_simple(ACT_LISTEN, 7, 0, r);
		do_simple(ACT_READ, 0, 0, r);
		do_simple(ACT_LISTEN, 1, 0, r);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_SYN, 32'hFFFF_FFFE, 0, 0);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_DATA, 32'hFFFF_FFFE, 3, 3);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_DATA, 32'h0000_0005, 2, 2);
		do_simple(ACT_READ, 1, 0, r);
		do_simple(ACT_PAYLOAD, 0, 0, r);
		do_header(8'h00, 16'h1234, 16'h4321, SEG_SYNACK, 0, 0, 0);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_DATAACK, 0, 0, 0);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_SYN, 0, 0, 0);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_FIN, 0, 0, 0);
		do_simple(ACT_CLOSE, 1, 0, r);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_FIN, 0, 0, 0);
		do_header(8'hFF, 16'hFFFF, 16'hFFFF, SEG_FINACK, 0, 0, 0);
		repeat (10) do_simple(ACT_TICK, 0, 0, r);
		do_simple(ACT_READ, 1, 0, r);
		do_simple(ACT_CLOSE, 1, 0, r);
		do_simple(ACT_NONE, 0, 0, r);
		for (int i = 0; i < NUM_CONN + 1; i++)
			do_simple(ACT_OPEN, 0, 16'(16'h0100 + i), r);
		for (int i = 0; i < NUM_CONN; i++)
			do_simple(ACT_CLOSE, 3'(i), 0, r);
	endtask

	task automatic test_full_buffer();
		conn_result_t r;
		logic [2:0] s;
		do_simple(ACT_OPEN, 0, 16'h5555, r);
		s = r.slot;
		do_simple(ACT_LISTEN, s, 0, r);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_SYN, 32'h8000_0000, 0, 0);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_DATA, exp_seq_m[s], 13'd4096, 6);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_DATA, exp_seq_m[s], 13'd4091, 1);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_DATA, exp_seq_m[s], 13'd4090, 3);
		repeat (5) do_simple(ACT_READ, s, 0, r);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_DATA, 32'h0000_1234, 2, 2);
		do_header(8'h5A, 16'hAAAA, 16'h5555, SEG_FIN, 0, 6, 2);
		set_ticks(16'd1);
		do_simple(ACT_TICK, 0, 0, r);
		do_simple(ACT_CLOSE, s, 0, r);
	endtask

	task automatic random_noise();
		conn_req_t q;
		conn_result_t r;
		q = '0;
		q.sock = 3'($urandom());
		q.lport = 16'($urandom());
		q.node = 8'($urandom());
		q.sport = ($urandom_range(0, 1)) ? 16'($urandom()) : 16'($urandom_range(0, 3));
		q.dport = ($urandom_range(0, 1)) ? 16'($urandom()) : 16'($urandom_range(0, 3));
		q.seg = 3'($urandom_range(0, 5));
		q.seq = $urandom();
		q.len = 13'($urandom_range(0, 4096));
		q.pbyte = 8'($urandom());
		q.action = 3'($urandom_range(0, 7));
		send_req(q, r);
	endtask

	task automatic random_session();
		conn_result_t r;
		logic [2:0] s;
		logic [15:0] sp, cp;
		logic [7:0] node;
		int n, len;
		sp = 16'($urandom_range(0, 3));
		cp = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
		node = 8'($urandom());
		do_simple(ACT_OPEN, 0, sp, r);
		s = (r.rc == RC_OK) ? r.slot : 3'($urandom_range(0, 7));
		do_simple(ACT_LISTEN, s, 0, r);
		do_header(node, cp, sp, SEG_SYN, $urandom(), 0, 0);
		n = $urandom_range(1, 5);
		for (int k = 0; k < n; k++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 6);
			do_header(node, cp, sp, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 5)) :
				SEG_DATA, ($urandom_range(0, 4) == 0) ? 32'($urandom()) : exp_seq_m[s],
				13'(len), ($urandom_range(0, 7) == 0) ? $urandom_range(0, len + 2) : len);
			repeat ($urandom_range(0, 4)) do_simple(ACT_READ, s, 0, r);
			if ($urandom_range(0, 6) == 0)
				random_noise();
		end
		if ($urandom_range(0, 4) != 0) begin
			do_header(node, cp, sp, SEG_FIN, $urandom(), 0, 0);
			if ($urandom_range(0, 1))
				do_header(node, cp, sp, SEG_FIN, $urandom(), 0, 0);
			repeat ($urandom_range(0, 3)) do_simple(ACT_READ, s, 0, r);
			repeat ($urandom_range(0, (int'(cw_ticks) < 12) ? int'(cw_ticks) + 1 : 12))
				do_simple(ACT_TICK, 0, 0, r);
		end
		if ($urandom_range(0, 3) != 0)
			do_simple(ACT_CLOSE, s, 0, r);
	endtask

	task automatic test_random(input int items);
		int target;
		target = sent + items;
		while (sent < target) begin
			if ($urandom_range(0, 3) == 0)
				random_noise();
			else
				random_session();
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1;
				repeat (300) @(negedge clk);
				hold_rx = 0;
			end
		join_none
		repeat (12) random_noise();
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		in_valid = 0;
		{action, sock_index, local_port, seg_node, seg_sport, seg_dport, seg_type,
			seq_num, payload_len, payload_byte} = '0;
		out_ready = 0;
		hold_rx = 0;
		errors = 0;
		sent = 0;
		table_reset();
		repeat (2) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_backpressure();
		test_full_buffer();
		set_ticks(16'd2);
		test_random(200);
		set_ticks(16'hFFFF);
		test_random(130);
		set_ticks(16'd1);
		test_random(130);
		set_ticks(16'd4);
		test_backpressure();
		test_random(140);
		drain();
		in_valid = 0;
		repeat (30) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
